// File: rtl/fsft_pkg.sv
// Shared types and constants of the first free slot table.
package fsft_pkg;

   localparam int SLOTS_DEF      = 64;
   localparam int DATA_WIDTH_DEF = 32;
   localparam int CAP_RESET      = 64;

   typedef enum logic [1:0] {
      KIND_INSERT = 2'd0,
      KIND_REMOVE = 2'd1,
      KIND_GET    = 2'd2,
      KIND_CLEAR  = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef struct packed {
      kind_type    kind;
      logic [5:0]  slot_index;
      logic [31:0] entry_data;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [5:0]  result_slot;
      logic [31:0] result_data;
      logic [6:0]  occupied_count;
   } rsp_type;

endpackage

// File: rtl/fsft_pick.sv
// Lowest free slot finder over the free mask.
module fsft_pick
   import fsft_pkg::*;
#(
   parameter int SLOTS = SLOTS_DEF
) (
   input  logic [SLOTS-1:0]         free_mask,
   output logic                     found,
   output logic [$clog2(SLOTS)-1:0] slot
);

   localparam int IW = $clog2(SLOTS);

   always_comb begin
      found = |free_mask;
      slot  = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (free_mask[i]) begin
            slot = IW'(i);
         end
      end
   end

endmodule

// File: rtl/first_free_slot_table_core.sv
// Top level of the first free slot table: valid marks, count, data memory, handshakes.
//
// A table of SLOTS data words, each with a valid mark, and a count of occupied slots.
// Each request item (insert, remove, get, clear) gives exactly one response item.
// Insert, clear and every error finish in the cycle of acceptance: the response is
// registered and shows the next cycle, so these run at one item per cycle while rsp_ready
// stays high. A successful remove or get reads the data memory through its registered
// read port, so the block waits in S_READ before taking the next request. The lowest
// free slot below the capacity is found by a priority encoder over the valid marks,
// which live in flip-flops and are cleared at once by reset and by a clear item. The
// data memory has no reset; only entries that were written are read. The capacity
// register (csr_data) saturates at SLOTS. The user must write it only while idle; not enforced.
module first_free_slot_table_core
   import fsft_pkg::*;
#(
   parameter int SLOTS      = SLOTS_DEF,
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  req_type    req_item,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp_item,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [6:0] csr_data
);

   localparam int IW = $clog2(SLOTS);
   localparam int CW = $clog2(SLOTS + 1);
   localparam logic [CW-1:0] CAP_INIT = CW'((SLOTS < CAP_RESET) ? SLOTS : CAP_RESET);

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_READ = 2'b10
   } state_type;

   // control state
   state_type       state_ff, state_in;
   logic [SLOTS-1:0] valid_ff, valid_in;
   logic [CW-1:0]   count_ff, count_in;
   logic [CW-1:0]   cap_ff, cap_in;
   logic            rsp_valid_ff, rsp_valid_in;
   // payload
   rsp_type         rsp_ff, rsp_in;

   // data memory
   logic [DATA_WIDTH-1:0] mem [SLOTS];
   logic [DATA_WIDTH-1:0] rd_data_ff;
   logic                  wr_en, rd_en;
   logic [IW-1:0]         wr_addr, rd_addr;

   logic            req_fire, rsp_fire;
   logic [SLOTS-1:0] free_mask;
   logic            free_found;
   logic [IW-1:0]   free_slot;
   logic            idx_in_range, hit, ins_ok;
   logic [CW-1:0]   count_dec;

   assign req_fire  = req_valid && req_ready;
   assign rsp_fire  = rsp_valid_ff && rsp_ready;
   assign req_ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;
   assign csr_ready = 1'b1;

   // capacity saturates at SLOTS
   always_comb begin
      cap_in = cap_ff;
      if (csr_valid) begin
         if (32'(csr_data) > 32'(SLOTS)) begin
            cap_in = CW'(SLOTS);
         end else begin
            cap_in = CW'(csr_data);
         end
      end
   end

   // free slots below the capacity
   always_comb begin
      for (int i = 0; i < SLOTS; i++) begin
         free_mask[i] = !valid_ff[i] && (CW'(i) < cap_ff);
      end
   end

   fsft_pick #(
      .SLOTS(SLOTS)
   ) u_pick (
      .free_mask(free_mask),
      .found    (free_found),
      .slot     (free_slot)
   );

   assign ins_ok       = free_found && (count_ff < cap_ff);
   assign idx_in_range = (CW + 6)'(req_item.slot_index) < (CW + 6)'(cap_ff);
   assign rd_addr      = IW'(req_item.slot_index);
   assign hit          = idx_in_range && valid_ff[rd_addr];
   assign count_dec    = (count_ff != '0) ? count_ff - 1'b1 : count_ff;
   assign wr_addr      = free_slot;

   always_comb begin
      state_in     = state_ff;
      valid_in     = valid_ff;
      count_in     = count_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_fire ? 1'b0 : rsp_valid_ff;
      wr_en        = 1'b0;
      rd_en        = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               rsp_in.result_data = '0;
               unique case (req_item.kind)
                  KIND_INSERT: begin
                     rsp_valid_in = 1'b1;
                     if (ins_ok) begin
                        wr_en               = 1'b1;
                        valid_in[free_slot] = 1'b1;
                        count_in            = count_ff + 1'b1;
                        rsp_in.status       = ST_OK;
                        rsp_in.result_slot  = 6'(free_slot);
                     end else begin
                        rsp_in.status       = ST_FULL;
                        rsp_in.result_slot  = '0;
                     end
                  end
                  KIND_REMOVE, KIND_GET: begin
                     rsp_in.result_slot = req_item.slot_index;
                     if (hit) begin
                        // data comes from the memory next cycle; response held back
                        rd_en         = 1'b1;
                        rsp_valid_in  = 1'b0;
                        rsp_in.status = ST_OK;
                        state_in      = S_READ;
                        if (req_item.kind == KIND_REMOVE) begin
                           valid_in[rd_addr] = 1'b0;
                           count_in          = count_dec;
                        end
                     end else begin
                        rsp_valid_in  = 1'b1;
                        rsp_in.status = ST_EMPTY;
                     end
                  end
                  KIND_CLEAR: begin
                     rsp_valid_in       = 1'b1;
                     valid_in           = '0;
                     count_in           = '0;
                     rsp_in.status      = ST_OK;
                     rsp_in.result_slot = '0;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
               rsp_in.occupied_count = 7'(count_in);
            end
         end
         S_READ: begin
            rsp_in.result_data = 32'(rd_data_ff);
            rsp_valid_in       = 1'b1;
            state_in           = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         valid_ff     <= '0;
         count_ff     <= '0;
         cap_ff       <= CAP_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         count_ff     <= count_in;
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   // single write port, single registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= DATA_WIDTH'(req_item.entry_data);
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // count always matches the number of valid marks
   a_count_matches: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) == 32'($countones(valid_ff)))
      else $error("occupancy count differs from valid marks");

   // while waiting on the memory the output register must be free
   a_read_out_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_READ) |-> !rsp_valid_ff)
      else $error("output register busy during memory read");

   // a memory read always yields its response in the next cycle
   a_read_then_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_READ) |=> (rsp_valid_ff && state_ff == S_IDLE))
      else $error("read response not delivered");

endmodule

// File: dv/slot_table_checker.sv
// Checker for the slot table: mirrors the table, predicts each response item and compares.
`timescale 1ns / 100ps

module slot_table_checker
   import fsft_pkg::*;
#(
   parameter int SLOTS = SLOTS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_ready,
   input  req_type    req_item,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  rsp_type    rsp_item,
   input  logic       csr_valid,
   input  logic       csr_ready,
   input  logic [6:0] csr_data,
   output int         fail_count,
   output int         pending
);

   logic [31:0] word_mirror [SLOTS];
   bit          live_mirror [SLOTS];
   int unsigned live_total;
   int unsigned cap_mirror;
   rsp_type     due_q [$];

   // Applies one item to the mirror and returns the response it should give.
   function automatic rsp_type predict_table_op(req_type r);
      rsp_type o;
      o = '0;
      o.status = ST_OK;
      case (r.kind)
         KIND_INSERT: begin
            o.status = ST_FULL;
            if (live_total < cap_mirror) begin
               for (int i = 0; i < cap_mirror && i < SLOTS; i++) begin
                  if (!live_mirror[i]) begin
                     live_mirror[i] = 1'b1;
                     word_mirror[i] = r.entry_data;
                     live_total++;
                     o.status      = ST_OK;
                     o.result_slot = 6'(i);
                     break;
                  end
               end
            end
         end
         KIND_REMOVE, KIND_GET: begin
            o.result_slot = r.slot_index;
            if (r.slot_index >= cap_mirror || !live_mirror[r.slot_index]) begin
               o.status = ST_EMPTY;
            end else begin
               o.result_data = word_mirror[r.slot_index];
               if (r.kind == KIND_REMOVE) begin
                  live_mirror[r.slot_index] = 1'b0;
                  if (live_total > 0) live_total--;
               end
            end
         end
         default: begin
            foreach (live_mirror[i]) live_mirror[i] = 1'b0;
            live_total = 0;
         end
      endcase
      o.occupied_count = 7'(live_total);
      return o;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         foreach (live_mirror[i]) live_mirror[i] = 1'b0;
         live_total = 0;
         cap_mirror = (CAP_RESET > SLOTS) ? SLOTS : CAP_RESET;
         due_q.delete();
      end else begin
         // response first: it can never belong to an item taken at this same edge
         if (rsp_valid && rsp_ready) begin
            if (due_q.size() == 0) begin
               $display("%0t: response item with none expected, got %h", $time, rsp_item);
               fail_count++;
            end else begin
               want = due_q.pop_front();
               if (rsp_item.status !== want.status) begin
                  $display("%0t: status expected %0d got %0d", $time, want.status,
                           rsp_item.status);
                  fail_count++;
               end
               if (rsp_item.result_slot !== want.result_slot) begin
                  $display("%0t: slot expected %0d got %0d", $time, want.result_slot,
                           rsp_item.result_slot);
                  fail_count++;
               end
               if (rsp_item.result_data !== want.result_data) begin
                  $display("%0t: data expected %h got %h", $time, want.result_data,
                           rsp_item.result_data);
                  fail_count++;
               end
               if (rsp_item.occupied_count !== want.occupied_count) begin
                  $display("%0t: count expected %0d got %0d", $time, want.occupied_count,
                           rsp_item.occupied_count);
                  fail_count++;
               end
            end
         end
         if (req_valid && req_ready) due_q.push_back(predict_table_op(req_item));
         if (csr_valid && csr_ready) cap_mirror = (csr_data > SLOTS) ? SLOTS : csr_data;
      end
      pending = due_q.size();
   end

endmodule

// File: dv/tb_first_free_slot_table_core.sv
// Testbench top for the first free slot table: stimulus, idling, capacity phases and verdict.
`timescale 1ns / 100ps

module tb_first_free_slot_table_core;
   import fsft_pkg::*;

   // generous limit for about 1850 items plus stalls
   localparam int LIMIT_CYCLES = 200000;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   req_type    req_item = '0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   rsp_type    rsp_item;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [6:0] csr_data = '0;

   int fails;
   int pending;
   int cycles = 0;
   int sent = 0;             // items offered and taken, directed and random
   int unsigned cap_now = CAP_RESET;  // capacity as the stimulus believes it
   bit calm = 1'b0;          // no idling on either side while set
   bit squeeze = 1'b0;       // asks the receiver for one long hold-off

   first_free_slot_table_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   slot_table_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_item   (req_item),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_item   (rsp_item),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .fail_count (fails),
      .pending    (pending)
   );

   always #4 clock = ~clock;

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == LIMIT_CYCLES) begin
         $display("first_free_slot_table_core: mismatch");
         $finish;
      end
   end

   // Receiver: random stalls, none while calm, and one long hold-off when asked.
   // The hold-off is timed here, so the sender keeps offering items meanwhile and
   // the block backs up until it drops req_ready.
   initial begin
      int hold_left;
      bit held_once;
      hold_left = 0;
      held_once = 1'b0;
      forever begin
         @(negedge clock);
         if (squeeze && !held_once) begin
            hold_left = 200;
            held_once = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= calm || ($urandom_range(99) >= 21);
         end
      end
   end

   // Offers one item and returns at the falling edge after it was taken. Valid is
   // left high, so back-to-back items never see it dropped and raised in one step.
   task automatic offer(input kind_type k, input logic [5:0] idx, input logic [31:0] d);
      req_type r;
      r.kind       = k;
      r.slot_index = idx;
      r.entry_data = d;
      if (!calm) begin
         while ($urandom_range(99) < 21) begin
            req_valid <= 1'b0;
            @(negedge clock);
         end
      end
      req_valid <= 1'b1;
      req_item  <= r;
      do @(posedge clock); while (!req_ready);
      sent++;
      @(negedge clock);
   endtask

   // Drops valid and waits for every outstanding response item, plus a short
   // margin for the registered read path.
   task automatic settle();
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // Capacity writes happen only with the block drained.
   task automatic set_capacity(input logic [6:0] v);
      settle();
      csr_valid <= 1'b1;
      csr_data  <= v;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      cap_now = (v > 7'd64) ? 64 : v;
   endtask

   // One random step. Indexes lean towards the reachable range (and one past it)
   // so that most removes and gets hit live slots; a rare fill burst of inserts
   // drives the table into its full state whatever the capacity.
   task automatic random_item();
      int unsigned pick;
      int unsigned hi;
      logic [5:0]  idx;
      pick = $urandom_range(99);
      hi   = (cap_now > 63) ? 63 : cap_now;
      idx  = ($urandom_range(99) < 75) ? 6'($urandom_range(hi)) : 6'($urandom_range(63));
      if (pick < 2)
         repeat (cap_now + 2) offer(KIND_INSERT, 6'($urandom), $urandom);
      else if (pick < 45)
         offer(KIND_INSERT, 6'($urandom), $urandom);
      else if (pick < 70)
         offer(KIND_REMOVE, idx, $urandom);
      else if (pick < 98)
         offer(KIND_GET, idx, $urandom);
      else
         offer(KIND_CLEAR, idx, $urandom);
   endtask

   initial begin
      logic [6:0] plan_cap [8];
      int         quota;
      plan_cap = '{7'd64, 7'd5, 7'd1, 7'd127, 7'd40, 7'd0, 7'd17, 7'd64};
      plan_cap[6] = 7'($urandom_range(63, 2));

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // --- directed, at reset capacity ---
      offer(KIND_GET,    6'd0,  32'h1234_5678);  // empty slot
      offer(KIND_REMOVE, 6'd63, 32'h0);          // empty top slot
      offer(KIND_INSERT, 6'd63, 32'h0000_0000);  // slot 0
      offer(KIND_INSERT, 6'd0,  32'hFFFF_FFFF);  // slot 1
      offer(KIND_INSERT, 6'd21, 32'hA5A5_A5A5);  // slot 2
      offer(KIND_GET,    6'd1,  32'h0);
      offer(KIND_REMOVE, 6'd0,  32'hFFFF_FFFF);
      offer(KIND_REMOVE, 6'd0,  32'h0);          // already freed
      offer(KIND_INSERT, 6'd42, 32'h5A5A_5A5A);  // reuses the hole at slot 0
      offer(KIND_GET,    6'd63, 32'h0);
      offer(KIND_CLEAR,  6'd63, 32'hFFFF_FFFF);
      offer(KIND_GET,    6'd1,  32'h0);          // gone after clear

      // tiny table: fills after two, then a freed slot is reused
      set_capacity(7'd2);
      offer(KIND_INSERT, 6'd0, 32'hDEAD_BEEF);
      offer(KIND_INSERT, 6'd0, 32'hCAFE_F00D);
      offer(KIND_INSERT, 6'd0, 32'h0BAD_0BAD);   // full
      offer(KIND_REMOVE, 6'd1, 32'h0);
      offer(KIND_INSERT, 6'd0, 32'h7777_0001);

      // zero capacity with live slots: all full or out of range
      set_capacity(7'd0);
      offer(KIND_INSERT, 6'd0, 32'h1111_1111);
      offer(KIND_GET,    6'd0, 32'h0);
      offer(KIND_REMOVE, 6'd0, 32'h0);

      // above the slot count saturates, and the old slots become reachable again
      set_capacity(7'd127);
      offer(KIND_GET, 6'd0, 32'h0);
      offer(KIND_GET, 6'd1, 32'h0);

      // --- random phases, each at its own capacity, no clear in between so
      // lowering the capacity often leaves live slots beyond its reach ---
      for (int p = 0; p < 8; p++) begin
         set_capacity(plan_cap[p]);
         calm    = (p == 1);
         squeeze = squeeze || (p == 3);
         quota   = sent + ((plan_cap[p] == 0) ? 40 : 258);
         while (sent < quota) random_item();
      end
      calm = 1'b0;

      settle();
      if (fails == 0 && pending == 0)
         $display("first_free_slot_table_core: match");
      else
         $display("first_free_slot_table_core: mismatch");
      $finish;
   end

endmodule

// File: sim.f
rtl/fsft_pkg.sv
rtl/fsft_pick.sv
rtl/first_free_slot_table_core.sv
dv/slot_table_checker.sv
dv/tb_first_free_slot_table_core.sv
